FILE: rtl/glos_pkg.sv
package glos_pkg;

  localparam int GRID_SIDE = 1024;
  localparam int COORD_W   = 10;
  localparam int LEVEL_W   = 8;
  localparam int ROW_W     = $clog2(GRID_SIDE);
  localparam int ERR_W     = COORD_W + 3;

  typedef logic [COORD_W-1:0]      coord_t;
  typedef logic [LEVEL_W-1:0]      level_t;
  typedef logic [ROW_W-1:0]        row_t;
  typedef logic signed [ERR_W-1:0] err_t;
  typedef logic signed [ERR_W:0]   err2_t;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  // Port request into the occupancy map.
  typedef struct packed {
    logic clr;
    logic wr;
    row_t wr_row;
    row_t wr_col;
    logic wr_bit;
    row_t rd_row;
    row_t rd_col;
  } map_req_t;

  function automatic logic cell_inside(coord_t x, coord_t y);
    return (32'(x) < 32'(GRID_SIDE)) && (32'(y) < 32'(GRID_SIDE));
  endfunction

  function automatic row_t to_row(coord_t c);
    return row_t'(c);
  endfunction

endpackage

FILE: rtl/glos_if.sv
interface glos_in_if;
  logic                   valid;
  logic                   ready;
  logic                   op;
  glos_pkg::coord_t       start_x;
  glos_pkg::coord_t       start_y;
  glos_pkg::coord_t       end_x;
  glos_pkg::coord_t       end_y;
  glos_pkg::level_t       cell_level;

  modport source (output valid, op, start_x, start_y, end_x, end_y, cell_level,
                  input ready);
  modport sink   (input valid, op, start_x, start_y, end_x, end_y, cell_level,
                  output ready);
endinterface

interface glos_out_if;
  logic valid;
  logic ready;
  logic visible;

  modport source (output valid, visible, input ready);
  modport sink   (input valid, visible, output ready);
endinterface

FILE: rtl/glos_map.sv
module glos_map (
  input  logic               clk_i,
  input  glos_pkg::map_req_t req_i,
  output logic               rd_bit_o
);
  import glos_pkg::*;

  // One row per grid row, one bit per cell.
  logic [GRID_SIDE-1:0] mem_q [GRID_SIDE];

  always_ff @(posedge clk_i) begin
    if (req_i.clr) begin
      mem_q[req_i.wr_row] <= '0;
    end else if (req_i.wr) begin
      mem_q[req_i.wr_row][req_i.wr_col] <= req_i.wr_bit;
    end
    rd_bit_o <= mem_q[req_i.rd_row][req_i.rd_col];
  end

endmodule

FILE: rtl/grid_line_of_sight_check.sv
// Line-of-sight checker over a GRID_SIDE x GRID_SIDE occupancy map.
// in_i carries one beat per item: op=write stores one cell (blocked when
// cell_level is nonzero, ignored outside the grid), op=query walks the
// Bresenham line from (start_x,start_y) to (end_x,end_y), both ends included.
// out_o carries one beat per query: visible=1 when no cell on the line is
// blocked. Writes give no beat.
// A write leaves the block idle, so in_i.ready stays high after it.
// A query visits n = max(|dx|,|dy|) + 1 cells (at most GRID_SIDE) and stops
// early at the first blocked cell: one map read per cell, issued back to
// back from a single step unit, with the registered map read behind it.
// in_i.ready is low for the whole walk and returns with the result when the
// output register is free, so the block takes no new item while a query is
// in progress.
// After reset the map is swept clear one row per cycle while in_i.ready
// stays low.
// The result sits in an output register; a stalled receiver holds it there,
// and the block keeps taking writes and starts the next query meanwhile,
// parking that result, with in_i.ready low, until the register frees up.
module grid_line_of_sight_check (
  input  logic       clk_i,
  input  logic       rst_ni,
  glos_in_if.sink    in_i,
  glos_out_if.source out_o
);
  import glos_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SETUP,
    S_WALK,
    S_DONE
  } state_e;

  state_e   state_q;
  row_t     clr_q;
  coord_t   cx_q, cy_q, ex_q, ey_q, dx_q, dy_q;
  logic     sx_neg_q, sy_neg_q;
  err_t     err_q;
  logic     issue_q, pend_q, pend_end_q, pend_in_q, res_q;
  logic     out_valid_q, visible_q;

  logic     accept, is_query, at_end, step_x, step_y, rd_bit;
  err2_t    e2, dx_e, dy_e;
  err_t     dx_s, dy_s, err_next;
  coord_t   cx_next, cy_next;
  map_req_t map_req;

  assign in_i.ready    = (state_q == S_IDLE);
  assign accept        = in_i.valid && in_i.ready;
  assign is_query      = (op_e'(in_i.op) == OP_QUERY);
  assign out_o.valid   = out_valid_q;
  assign out_o.visible = visible_q;

  // Bresenham step unit
  always_comb begin
    dx_s     = err_t'({1'b0, dx_q});
    dy_s     = err_t'({1'b0, dy_q});
    dx_e     = err2_t'(dx_s);
    dy_e     = err2_t'(dy_s);
    e2       = err2_t'({err_q, 1'b0});
    step_x   = (e2 > -dy_e);
    step_y   = (e2 < dx_e);
    err_next = err_q - (step_x ? dy_s : '0) + (step_y ? dx_s : '0);
    cx_next  = step_x ? (sx_neg_q ? cx_q - 1'b1 : cx_q + 1'b1) : cx_q;
    cy_next  = step_y ? (sy_neg_q ? cy_q - 1'b1 : cy_q + 1'b1) : cy_q;
    at_end   = (cx_q == ex_q) && (cy_q == ey_q);
  end

  always_comb begin
    map_req.clr    = (state_q == S_CLEAR);
    map_req.wr     = accept && !is_query && cell_inside(in_i.start_x, in_i.start_y);
    map_req.wr_row = map_req.clr ? clr_q : to_row(in_i.start_x);
    map_req.wr_col = to_row(in_i.start_y);
    map_req.wr_bit = |in_i.cell_level;
    map_req.rd_row = to_row(cx_q);
    map_req.rd_col = to_row(cy_q);
  end

  glos_map u_map (
    .clk_i    (clk_i),
    .req_i    (map_req),
    .rd_bit_o (rd_bit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      cx_q        <= '0;
      cy_q        <= '0;
      ex_q        <= '0;
      ey_q        <= '0;
      dx_q        <= '0;
      dy_q        <= '0;
      sx_neg_q    <= 1'b0;
      sy_neg_q    <= 1'b0;
      err_q       <= '0;
      issue_q     <= 1'b0;
      pend_q      <= 1'b0;
      pend_end_q  <= 1'b0;
      pend_in_q   <= 1'b0;
      res_q       <= 1'b0;
      out_valid_q <= 1'b0;
      visible_q   <= 1'b0;
    end else begin
      if (out_o.ready && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == row_t'(GRID_SIDE - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept && is_query) begin
            cx_q     <= in_i.start_x;
            cy_q     <= in_i.start_y;
            ex_q     <= in_i.end_x;
            ey_q     <= in_i.end_y;
            dx_q     <= (in_i.end_x > in_i.start_x) ? in_i.end_x - in_i.start_x
                                                    : in_i.start_x - in_i.end_x;
            dy_q     <= (in_i.end_y > in_i.start_y) ? in_i.end_y - in_i.start_y
                                                    : in_i.start_y - in_i.end_y;
            sx_neg_q <= !(in_i.start_x < in_i.end_x);
            sy_neg_q <= !(in_i.start_y < in_i.end_y);
            state_q  <= S_SETUP;
          end
        end
        S_SETUP: begin
          err_q   <= dx_s - dy_s;
          issue_q <= 1'b1;
          pend_q  <= 1'b0;
          state_q <= S_WALK;
        end
        S_WALK: begin
          // issue side: read the current cell, then advance
          pend_q     <= issue_q;
          pend_end_q <= at_end;
          pend_in_q  <= cell_inside(cx_q, cy_q);
          if (issue_q) begin
            if (at_end) begin
              issue_q <= 1'b0;
            end else begin
              cx_q  <= cx_next;
              cy_q  <= cy_next;
              err_q <= err_next;
            end
          end
          // check side: handles the read issued in the previous cycle
          if (pend_q) begin
            if (!pend_in_q || rd_bit) begin
              res_q   <= 1'b0;
              state_q <= S_DONE;
            end else if (pend_end_q) begin
              res_q   <= 1'b1;
              state_q <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            visible_q   <= res_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/glos_checker.sv
module glos_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic in_op_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_visible_i
);
  import glos_pkg::*;

  logic in_beat;
  assign in_beat = in_valid_i && in_ready_i;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_visible_i))
    else $error("result changed or dropped while stalled");

  // a query occupies the block for its walk
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && (op_e'(in_op_i) == OP_QUERY) |=> !in_ready_i)
    else $error("input ready right after a query beat");

  // no item produces a result on the very next edge
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && !out_valid_i |=> !out_valid_i)
    else $error("result appeared one cycle after an input beat");

endmodule

bind grid_line_of_sight_check glos_checker u_glos_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_op_i       (in_i.op),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_visible_i (out_o.visible)
);

FILE: sim/grid_line_of_sight_check_test.sv
module grid_line_of_sight_check_test;
  timeunit 1ns;
  timeprecision 1ps;

  import glos_pkg::*;

  localparam coord_t MAX_C       = coord_t'(GRID_SIDE - 1);
  localparam int     RANDOM_REQS = 560;
  localparam int     LONG_HOLD   = 400;
  localparam int     STALL_LIMIT = 20000;
  localparam int     END_WAIT    = GRID_SIDE + 8;

  typedef struct packed {
    op_e    op;
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    level_t level;
    logic   drain;
  } los_req_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  glos_in_if  in_if ();
  glos_out_if out_if ();

  grid_line_of_sight_check DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #5 clk_i = ~clk_i;

  // Occupancy mirror, indexed [row][column].
  bit [GRID_SIDE-1:0] blocked_rows [GRID_SIDE];

  los_req_t pending_reqs [$];
  bit       visible_due  [$];
  los_req_t cur_req;
  bit       next_drain;

  int  in_gap, in_quiet, out_stall, out_quiet, out_hold;
  int  results_seen, err_count, idle_cycles;
  int  n_writes, n_queries, n_blocked;
  logic want_visible;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 90);
  endfunction

  // Walk the Bresenham line, both ends included; stop at the first blocked cell.
  function automatic bit line_clear(coord_t x0, coord_t y0, coord_t x1, coord_t y1);
    int cx = x0;
    int cy = y0;
    int tx = x1;
    int ty = y1;
    int dx = (tx > cx) ? tx - cx : cx - tx;
    int dy = (ty > cy) ? ty - cy : cy - ty;
    int stx = (cx < tx) ? 1 : -1;
    int sty = (cy < ty) ? 1 : -1;
    int err = dx - dy;
    int e2;
    for (int n = 0; n <= 2 * GRID_SIDE + 2; n++) begin
      if (cx < 0 || cy < 0 || cx >= GRID_SIDE || cy >= GRID_SIDE) return 1'b0;
      if (blocked_rows[coord_t'(cx)][coord_t'(cy)]) return 1'b0;
      if (cx == tx && cy == ty) return 1'b1;
      e2 = 2 * err;
      if (e2 > -dy) begin
        err -= dy;
        cx += stx;
      end
      if (e2 < dx) begin
        err += dx;
        cy += sty;
      end
    end
    return 1'b1;
  endfunction

  task automatic push_write(int x, int y, level_t lvl);
    los_req_t r;
    r.op    = OP_WRITE;
    r.sx    = coord_t'(x);
    r.sy    = coord_t'(y);
    r.ex    = coord_t'($urandom);
    r.ey    = coord_t'($urandom);
    r.level = lvl;
    r.drain = next_drain;
    next_drain = 1'b0;
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  task automatic push_query(int x0, int y0, int x1, int y1);
    los_req_t r;
    r.op    = OP_QUERY;
    r.sx    = coord_t'(x0);
    r.sy    = coord_t'(y0);
    r.ex    = coord_t'(x1);
    r.ey    = coord_t'(y1);
    r.level = level_t'($urandom);
    r.drain = next_drain;
    next_drain = 1'b0;
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  // Driver: offer the next pending beat, predict on acceptance.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid      <= 1'b0;
      in_if.op         <= OP_WRITE;
      in_if.start_x    <= '0;
      in_if.start_y    <= '0;
      in_if.end_x      <= '0;
      in_if.end_y      <= '0;
      in_if.cell_level <= '0;
      in_gap   = 0;
      in_quiet = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        if (cur_req.op == OP_WRITE) begin
          n_writes++;
          if (cur_req.sx < GRID_SIDE && cur_req.sy < GRID_SIDE)
            blocked_rows[cur_req.sx][cur_req.sy] = (cur_req.level != '0);
        end else begin
          n_queries++;
          visible_due.insert(visible_due.size(),
                             line_clear(cur_req.sx, cur_req.sy, cur_req.ex, cur_req.ey));
          if (!visible_due[$]) n_blocked++;
        end
      end
      if (!in_if.valid || in_if.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_if.valid <= 1'b0;
        end else if (pending_reqs.size() > 0 &&
                     !(pending_reqs[0].drain && visible_due.size() > 0)) begin
          cur_req = pending_reqs.pop_front();
          in_if.valid      <= 1'b1;
          in_if.op         <= cur_req.op;
          in_if.start_x    <= cur_req.sx;
          in_if.start_y    <= cur_req.sy;
          in_if.end_x      <= cur_req.ex;
          in_if.end_y      <= cur_req.ey;
          in_if.cell_level <= cur_req.level;
          if (in_quiet > 0) in_quiet--;
          else if ($urandom_range(0, 39) == 0) in_quiet = $urandom_range(20, 60);
          in_gap = (in_quiet > 0) ? 0 : pick_gap();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result beat against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      out_stall = 0;
      out_quiet = 0;
      out_hold  = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (visible_due.size() == 0) begin
          $error("visible: expected no beat, got %0b", out_if.visible);
          err_count++;
        end else begin
          want_visible = visible_due.pop_front();
          if (out_if.visible !== want_visible) begin
            $error("visible: expected %0b, got %0b", want_visible, out_if.visible);
            err_count++;
          end
        end
        results_seen++;
        // Hold off long enough for the block to back up into its input.
        if (results_seen == 50 || results_seen == 140) begin
          out_hold = LONG_HOLD;
        end else begin
          if (out_quiet > 0) out_quiet--;
          else if ($urandom_range(0, 39) == 0) out_quiet = $urandom_range(20, 60);
          out_stall = (out_quiet > 0) ? 0 : pick_gap();
        end
      end
      if (out_hold > 0) begin
        out_hold--;
        out_if.ready <= 1'b0;
      end else if (out_stall > 0) begin
        out_stall--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("handshake timeout after %0d idle cycles", idle_cycles);
      $display("grid_line_of_sight_check test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int side, nw, nq, windows, kind;
    int bx, by, x0, y0, x1, y1, pos;

    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.op         = OP_WRITE;
    in_if.start_x    = '0;
    in_if.start_y    = '0;
    in_if.end_x      = '0;
    in_if.end_y      = '0;
    in_if.cell_level = '0;
    out_if.ready     = 1'b0;
    next_drain   = 1'b0;
    results_seen = 0;
    err_count    = 0;
    idle_cycles  = 0;
    n_writes     = 0;
    n_queries    = 0;
    n_blocked    = 0;
    windows      = 0;
    foreach (blocked_rows[i]) blocked_rows[i] = '0;

    // Directed: single cells, full-span lines, soft levels, clearing.
    push_query(0, 0, 0, 0);
    push_query(0, 0, MAX_C, MAX_C);
    push_write(MAX_C, MAX_C, 8'hFF);
    push_query(MAX_C, MAX_C, MAX_C, MAX_C);
    push_query(0, 0, MAX_C, MAX_C);
    push_query(MAX_C, MAX_C, 0, 0);
    push_write(MAX_C, MAX_C, 8'h00);
    push_query(0, MAX_C, MAX_C, 0);
    push_write(0, MAX_C, 8'h01);
    push_query(0, 0, 0, MAX_C);
    push_write(512, 0, 8'h80);
    push_query(0, 0, MAX_C, 0);
    push_query(MAX_C, 0, 0, 0);
    push_write(5, 5, 8'h7F);
    push_query(4, 4, 6, 6);
    push_query(6, 4, 4, 6);
    push_query(0, 0, MAX_C, 1);
    push_query(1, 0, 0, MAX_C);
    push_write(0, MAX_C, 8'h00);
    push_write(512, 0, 8'h00);
    push_query(0, MAX_C, 0, 0);
    push_query(MAX_C, 0, 0, 0);
    push_write(5, 5, 8'h00);
    push_query(6, 6, 4, 4);

    // Random: small windows salted with obstacles, then lines inside them.
    while (pending_reqs.size() < RANDOM_REQS + 24) begin
      windows++;
      if (windows % 8 == 0) next_drain = 1'b1;
      case ($urandom_range(0, 3))
        0, 1:    side = 8;
        2:       side = 16;
        default: side = 32;
      endcase
      bx = $urandom_range(0, GRID_SIDE - side);
      by = $urandom_range(0, GRID_SIDE - side);
      if ($urandom_range(0, 5) == 0) bx = $urandom_range(0, 1) ? 0 : GRID_SIDE - side;
      if ($urandom_range(0, 5) == 0) by = $urandom_range(0, 1) ? 0 : GRID_SIDE - side;

      nw = $urandom_range(3, side + 4);
      for (int i = 0; i < nw; i++)
        push_write(bx + $urandom_range(0, side - 1), by + $urandom_range(0, side - 1),
                   ($urandom_range(0, 9) < 4) ? 8'h00 : level_t'($urandom_range(1, 255)));

      nq = $urandom_range(3, 10);
      for (int i = 0; i < nq; i++) begin
        x0 = bx + $urandom_range(0, side - 1);
        y0 = by + $urandom_range(0, side - 1);
        x1 = bx + $urandom_range(0, side - 1);
        y1 = by + $urandom_range(0, side - 1);
        if ($urandom_range(0, 9) == 0) begin
          x1 = x0;
          y1 = y0;
        end
        push_query(x0, y0, x1, y1);
      end

      // Noise: a stray write anywhere on the grid.
      if ($urandom_range(0, 3) == 0)
        push_write(coord_t'($urandom), coord_t'($urandom), level_t'($urandom));

      // Now and then a line across the whole grid, sometimes with a blocker on it.
      if (windows % 6 == 3) begin
        kind = $urandom_range(0, 2);
        pos  = coord_t'($urandom);
        x0   = coord_t'($urandom);
        if (kind == 0) begin
          if ($urandom_range(0, 1)) push_write(x0, pos, level_t'($urandom_range(1, 255)));
          push_query(x0, 0, x0, MAX_C);
        end else if (kind == 1) begin
          if ($urandom_range(0, 1)) push_write(pos, pos, level_t'($urandom_range(1, 255)));
          push_query(MAX_C, MAX_C, 0, 0);
        end else begin
          push_query(coord_t'($urandom), coord_t'($urandom),
                     coord_t'($urandom), coord_t'($urandom));
        end
      end
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() > 0 || in_if.valid || visible_due.size() > 0)
      @(negedge clk_i);
    repeat (END_WAIT) @(posedge clk_i);

    $display("covered %0d cell writes and %0d line queries over %0d windows", n_writes,
             n_queries, windows);
    $display("%0d lines blocked, %0d results checked, %0d mismatches", n_blocked,
             results_seen, err_count);
    if (err_count == 0 && visible_due.size() == 0)
      $display("grid_line_of_sight_check test passed");
    else
      $display("grid_line_of_sight_check test failed");
    $finish;
  end

endmodule
